// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared property shorthands for clocked checks with an active-low reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ksl_pkg.sv =====
// ---------------------------------------------------------------------------
// ksl_pkg
// types and codes shared by the key slot lifecycle table
// ---------------------------------------------------------------------------
package ksl_pkg;

  // fixed field widths
  localparam int REQ_W      = 2;
  localparam int DEV_ID_W   = 16;
  localparam int KEY_W      = 64;
  localparam int STATUS_W   = 3;
  localparam int SLOT_IDX_W = 4;
  localparam int LIFE_W     = 3;
  localparam int USED_W     = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PROVISION = 2'd0,
    REQ_ROTATE    = 2'd1,
    REQ_REVOKE    = 2'd2,
    REQ_DESTROY   = 2'd3
  } req_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_BAD_STATE = 3'd2,
    STS_DUPLICATE = 3'd3,
    STS_FULL      = 3'd4
  } status_e;

  typedef enum logic [LIFE_W-1:0] {
    LIFE_PROVISIONED = 3'd0,
    LIFE_ACTIVE      = 3'd1,
    LIFE_ROTATED     = 3'd2,
    LIFE_REVOKED     = 3'd3,
    LIFE_DESTROYED   = 3'd4
  } life_e;

  // controller to datapath
  typedef struct packed {
    logic start;    // latch request, restart the search
    logic issue;    // read next slot
    logic capture;  // hold search outcome
    logic commit;   // update table, load response
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic table_empty;
    logic can_issue;
    logic cmp_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== sv/ksl_req_if.sv =====
// ---------------------------------------------------------------------------
// ksl_req_if
// request channel: valid/ready with request payload
// ---------------------------------------------------------------------------
interface ksl_req_if;
  logic                                valid;
  logic                                ready;
  ksl_pkg::req_kind_e                  req_type;
  logic [ksl_pkg::DEV_ID_W-1:0]        device_id;
  logic [ksl_pkg::KEY_W-1:0]           new_key;

  modport source (output valid, output req_type, output device_id, output new_key,
                  input ready);
  modport sink (input valid, input req_type, input device_id, input new_key,
                output ready);
endinterface

// ===== sv/ksl_rsp_if.sv =====
// ---------------------------------------------------------------------------
// ksl_rsp_if
// response channel: valid/ready with result payload
// ---------------------------------------------------------------------------
interface ksl_rsp_if;
  logic                                valid;
  logic                                ready;
  ksl_pkg::status_e                    status;
  logic [ksl_pkg::SLOT_IDX_W-1:0]      slot_index;
  ksl_pkg::life_e                      life_state;
  logic [ksl_pkg::USED_W-1:0]          slots_used;

  modport source (output valid, output status, output slot_index, output life_state,
                  output slots_used, input ready);
  modport sink (input valid, input status, input slot_index, input life_state,
                input slots_used, output ready);
endinterface

// ===== sv/key_slot_lifecycle_table.sv =====
// ---------------------------------------------------------------------------
// key_slot_lifecycle_table
// device key slot table with provision, rotate, revoke and destroy requests
// ---------------------------------------------------------------------------
//
// channel  dir  payload                              transfer
// req_i    in   req_type, device_id, new_key         valid & ready
// rsp_o    out  status, slot_index, life_state,      valid & ready
//               slots_used
//
// flow: one request at a time; a request scans the occupied slots in
//   order and stops early when the id hits; an empty table skips the scan
// the scan reads one slot ram entry per cycle and compares the id on the
//   registered read data in the cycle after the read
// reset: async active low clears the sequencer, the occupancy count and
//   the response valid; slot contents are only read below the count
// stalls: a held response does not block the next accept; the commit of
//   the following request waits until the response register is free
//
module key_slot_lifecycle_table #(
  parameter int MAX_SLOTS = 16,
  parameter int KEY_BITS  = 64,
  parameter int ID_BITS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ksl_req_if.sink      req_i,
  ksl_rsp_if.source    rsp_o
);

  // command and status between sequencer and datapath
  ksl_pkg::ctrl_cmd_t cmd;
  ksl_pkg::dp_sts_t   sts;
  logic               req_ready;

  // sequencer: idle / scan / commit
  ksl_ctrl u_ksl_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // datapath: slot ram, compare, update rules, response register
  ksl_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .KEY_BITS  (KEY_BITS),
    .ID_BITS   (ID_BITS)
  ) u_ksl_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_i.req_type),
    .device_id_i  (req_i.device_id),
    .new_key_i    (req_i.new_key),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .status_o     (rsp_o.status),
    .slot_index_o (rsp_o.slot_index),
    .life_state_o (rsp_o.life_state),
    .slots_used_o (rsp_o.slots_used)
  );

endmodule

// ===== sv/ksl_ram.sv =====
// ---------------------------------------------------------------------------
// ksl_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module ksl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ksl_ctrl.sv =====
// ---------------------------------------------------------------------------
// ksl_ctrl
// request sequencer: accept, scan the slot table, commit the update
// ---------------------------------------------------------------------------
module ksl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  ksl_pkg::dp_sts_t   sts_i,
  output ksl_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          // empty table: nothing to search
          state_d = sts_i.table_empty ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = sts_i.can_issue;
        if (sts_i.cmp_done) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/ksl_datapath.sv =====
// ---------------------------------------------------------------------------
// ksl_datapath
// slot storage, id compare, lifecycle update and response register
// ---------------------------------------------------------------------------
module ksl_datapath #(
  parameter int MAX_SLOTS = 16,
  parameter int KEY_BITS  = 64,
  parameter int ID_BITS   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ksl_pkg::ctrl_cmd_t               cmd_i,
  output ksl_pkg::dp_sts_t                 sts_o,
  input  ksl_pkg::req_kind_e               req_type_i,
  input  logic [ksl_pkg::DEV_ID_W-1:0]     device_id_i,
  input  logic [ksl_pkg::KEY_W-1:0]        new_key_i,
  input  logic                             rsp_ready_i,
  output logic                             rsp_valid_o,
  output ksl_pkg::status_e                 status_o,
  output logic [ksl_pkg::SLOT_IDX_W-1:0]   slot_index_o,
  output ksl_pkg::life_e                   life_state_o,
  output logic [ksl_pkg::USED_W-1:0]       slots_used_o
);

  localparam int IdxW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CntW    = $clog2(MAX_SLOTS + 1);
  localparam int LifeW   = ksl_pkg::LIFE_W;
  localparam int EntryW  = ID_BITS + LifeW + KEY_BITS;
  localparam int LifeLsb = KEY_BITS;
  localparam int IdLsb   = KEY_BITS + LifeW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SLOTS);

  // latched request
  ksl_pkg::req_kind_e  kind_q;
  logic [ID_BITS-1:0]  id_q;
  logic [KEY_BITS-1:0] key_q;

  // table occupancy and search
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     addr_q;
  logic [CntW-1:0]     cmp_idx_q;
  logic                cmp_vld_q;

  // search outcome
  logic                found_q;
  logic [IdxW-1:0]     hit_idx_q;
  ksl_pkg::life_e      hit_life_q;
  logic [KEY_BITS-1:0] hit_key_q;

  // response register
  logic                           rsp_valid_q;
  ksl_pkg::status_e               status_q, status_d;
  logic [IdxW-1:0]                idx_q, idx_d;
  ksl_pkg::life_e                 life_q, life_d;

  // ram access
  logic                we;
  logic [IdxW-1:0]     waddr;
  logic [EntryW-1:0]   wdata;
  logic [EntryW-1:0]   rdata;
  logic [ID_BITS-1:0]  rd_id;
  logic [LifeW-1:0]    rd_life;
  logic [KEY_BITS-1:0] rd_key;
  logic                match;
  ksl_pkg::life_e      new_life;
  logic [KEY_BITS-1:0] new_key;

  ksl_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_SLOTS)
  ) u_ksl_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (addr_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  assign rd_key  = rdata[KEY_BITS-1:0];
  assign rd_life = rdata[LifeLsb +: LifeW];
  assign rd_id   = rdata[IdLsb +: ID_BITS];
  assign match   = cmp_vld_q && (rd_id == id_q);

  assign sts_o.table_empty = (count_q == '0);
  assign sts_o.can_issue   = (addr_q < count_q);
  assign sts_o.cmp_done    = cmp_vld_q && (match || (cmp_idx_q == (count_q - CntW'(1))));
  assign sts_o.out_free    = !rsp_valid_q || rsp_ready_i;

  // request latch and scan pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      count_q   <= '0;
    end else begin
      cmp_vld_q <= cmd_i.issue;
      if (cmd_i.start) begin
        addr_q  <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.issue) begin
        addr_q <= addr_q + CntW'(1);
      end
      if (cmd_i.capture) begin
        found_q <= match;
      end
      if (cmd_i.commit) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= addr_q;
    if (cmd_i.start) begin
      kind_q <= req_type_i;
      id_q   <= ID_BITS'(device_id_i);
      key_q  <= KEY_BITS'(new_key_i);
    end
    if (cmd_i.capture) begin
      hit_idx_q  <= cmp_idx_q[IdxW-1:0];
      hit_life_q <= ksl_pkg::life_e'(rd_life);
      hit_key_q  <= rd_key;
    end
  end

  // lifecycle decision
  always_comb begin
    status_d = ksl_pkg::STS_OK;
    idx_d    = '0;
    life_d   = ksl_pkg::LIFE_PROVISIONED;
    count_d  = count_q;
    we       = 1'b0;
    waddr    = hit_idx_q;
    new_life = hit_life_q;
    new_key  = hit_key_q;
    if (kind_q == ksl_pkg::REQ_PROVISION) begin
      if (found_q) begin
        status_d = ksl_pkg::STS_DUPLICATE;
      end else if (count_q >= MaxCnt) begin
        status_d = ksl_pkg::STS_FULL;
      end else begin
        we       = 1'b1;
        waddr    = count_q[IdxW-1:0];
        new_life = ksl_pkg::LIFE_PROVISIONED;
        new_key  = key_q;
        idx_d    = count_q[IdxW-1:0];
        count_d  = count_q + CntW'(1);
      end
    end else if (!found_q) begin
      status_d = ksl_pkg::STS_NOT_FOUND;
    end else begin
      case (kind_q)
        ksl_pkg::REQ_ROTATE: begin
          if (hit_life_q inside {ksl_pkg::LIFE_REVOKED, ksl_pkg::LIFE_DESTROYED}) begin
            status_d = ksl_pkg::STS_BAD_STATE;
          end else begin
            new_key  = key_q;
            new_life = (hit_life_q == ksl_pkg::LIFE_PROVISIONED) ?
                       ksl_pkg::LIFE_ACTIVE : ksl_pkg::LIFE_ROTATED;
          end
        end
        ksl_pkg::REQ_REVOKE: begin
          if (hit_life_q == ksl_pkg::LIFE_DESTROYED) begin
            status_d = ksl_pkg::STS_BAD_STATE;
          end else begin
            new_life = ksl_pkg::LIFE_REVOKED;
          end
        end
        default: begin
          // destroy always goes through and wipes the key
          new_life = ksl_pkg::LIFE_DESTROYED;
          new_key  = '0;
        end
      endcase
      if (status_d == ksl_pkg::STS_OK) begin
        we    = 1'b1;
        idx_d = hit_idx_q;
      end
    end
    if (status_d == ksl_pkg::STS_OK) begin
      life_d = new_life;
    end
    we    = we && cmd_i.commit;
    wdata = {id_q, new_life, new_key};
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      idx_q    <= idx_d;
      life_q   <= life_d;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign status_o     = status_q;
  assign slot_index_o = ksl_pkg::SLOT_IDX_W'(idx_q);
  assign life_state_o = life_q;
  assign slots_used_o = ksl_pkg::USED_W'(count_q);

endmodule

// ===== sv/ksl_checker.sv =====
// ---------------------------------------------------------------------------
// ksl_checker
// port-level checks on the key slot lifecycle table
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ksl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [ksl_pkg::STATUS_W-1:0]   status_i,
  input logic [ksl_pkg::SLOT_IDX_W-1:0] slot_index_i,
  input logic [ksl_pkg::LIFE_W-1:0]     life_state_i,
  input logic [ksl_pkg::USED_W-1:0]     slots_used_i
);

  logic req_xfer;
  logic rsp_stall;
  logic failed;

  assign req_xfer  = req_valid_i && req_ready_i;
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;
  assign failed    = rsp_valid_i && (status_i != ksl_pkg::STS_OK);

  // a stalled response holds its payload
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i && $stable(status_i) && $stable(slot_index_i) && $stable(life_state_i) && $stable(slots_used_i))

  // only one request in flight
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_xfer, !req_ready_i)

  // failed requests report slot zero and state zero
  `ASSERT_IMPLIES(a_fail_zero, clk_i, rst_ni, failed, (slot_index_i == '0) && (life_state_i == ksl_pkg::LIFE_PROVISIONED))

endmodule

bind key_slot_lifecycle_table ksl_checker u_ksl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .slot_index_i (rsp_o.slot_index),
  .life_state_i (rsp_o.life_state),
  .slots_used_i (rsp_o.slots_used)
);
